>>> design/obdprd_pkg.sv
// ----------------------------------------------------------------------------
// OBD-II PID reply decoder package
// Character constants, status codes and the classified character request that
// passes from the front end through the queue to the decode back end.
// ----------------------------------------------------------------------------
package obdprd_pkg;

  // Characters of the adapter reply.
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_PROMPT = 8'd62;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_1      = 8'h31;
  localparam logic [7:0] CHAR_4      = 8'h34;
  localparam logic [7:0] CHAR_5      = 8'h35;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_C   = 8'h43;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;

  // Reply bookkeeping.
  localparam logic [3:0] KEPT_MAX     = 4'd8;
  localparam logic [3:0] HEADER_LEN   = 4'd4;
  localparam logic [3:0] BYTE_B_POS   = 4'd6;
  localparam logic [3:0] NEED_RPM     = 4'd8;
  localparam logic [3:0] NEED_TEMP    = 4'd6;
  localparam logic [14:0] TEMP_OFFSET = 15'd40;

  // Query kinds.
  localparam logic QUERY_RPM  = 1'b0;
  localparam logic QUERY_TEMP = 1'b1;

  // Result status codes.
  localparam logic [1:0] STS_VALID    = 2'd0;
  localparam logic [1:0] STS_HEADER   = 2'd1;
  localparam logic [1:0] STS_SHORT    = 2'd2;

  // Class of a character that is kept for the back end.
  typedef enum logic {
    CLS_KEEP   = 1'b0,
    CLS_PROMPT = 1'b1
  } chr_class_t;

  // One classified character request.
  typedef struct packed {
    chr_class_t cls;
    logic [3:0] hdr_hit;    // matches the header character at positions 0..3
    logic [3:0] nibble;     // hex value, zero when not a hex digit
    logic       hex_ok;
    logic       query_kind; // query kind in force when the character arrived
  } chr_item_t;

endpackage

>>> design/obdprd_front.sv
// ----------------------------------------------------------------------------
// OBD-II PID reply decoder front end
// Holds the query kind register, drops carriage returns and spaces, and
// classifies every other character into a request for the queue.
// ----------------------------------------------------------------------------
module obdprd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_char,
  output logic                  push,
  output obdprd_pkg::chr_item_t push_item,
  input  logic                  queue_full
);
  import obdprd_pkg::*;

  logic       query_kind_r;
  logic       query_kind_nxt;
  logic       is_drop;
  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] diff;

  // Query kind register; the user must write it only while the block is idle, the block does not enforce this.
  always_comb begin
    query_kind_nxt = query_kind_r;
    if (cfg_we) begin
      query_kind_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_kind_r <= QUERY_RPM;
    end else begin
      query_kind_r <= query_kind_nxt;
    end
  end

  // Character classification and hex decode.
  always_comb begin
    is_drop  = (in_rx_char == CHAR_CR) || (in_rx_char == CHAR_SPACE);
    is_digit = (in_rx_char >= CHAR_0) && (in_rx_char <= CHAR_9);
    is_upper = (in_rx_char >= CHAR_UC_A) && (in_rx_char <= CHAR_UC_F);
    is_lower = (in_rx_char >= CHAR_LC_A) && (in_rx_char <= CHAR_LC_F);

    if (is_digit) begin
      diff = in_rx_char - CHAR_0;
    end else if (is_upper) begin
      diff = in_rx_char - CHAR_UC_A + 8'd10;
    end else if (is_lower) begin
      diff = in_rx_char - CHAR_LC_A + 8'd10;
    end else begin
      diff = 8'd0;
    end

    push_item.cls        = (in_rx_char == CHAR_PROMPT) ? CLS_PROMPT : CLS_KEEP;
    push_item.hdr_hit[0] = (in_rx_char == CHAR_4);
    push_item.hdr_hit[1] = (in_rx_char == CHAR_1);
    push_item.hdr_hit[2] = (in_rx_char == CHAR_0);
    push_item.hdr_hit[3] = (query_kind_r == QUERY_TEMP) ? (in_rx_char == CHAR_5)
                                                        : (in_rx_char == CHAR_UC_C);
    push_item.nibble     = diff[3:0];
    push_item.hex_ok     = is_digit || is_upper || is_lower;
    push_item.query_kind = query_kind_r;
  end

  // Handshake: dropped characters are accepted and discarded.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full && !is_drop;

endmodule

>>> design/obdprd_queue.sv
// ----------------------------------------------------------------------------
// OBD-II PID reply decoder queue
// Short register queue of classified character requests between the front
// end and the decode back end.
// ----------------------------------------------------------------------------
module obdprd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  obdprd_pkg::chr_item_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output obdprd_pkg::chr_item_t pop_item
);
  import obdprd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chr_item_t        entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/obdprd_back.sv
// ----------------------------------------------------------------------------
// OBD-II PID reply decoder back end
// Tracks the reply (kept count, header match, data bytes, digit error) and
// on the prompt forms the result into the output register.
// ----------------------------------------------------------------------------
module obdprd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  obdprd_pkg::chr_item_t item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [14:0]    out_value,
  output logic [1:0]            out_status
);
  import obdprd_pkg::*;

  logic [3:0]         kept_count_r;
  logic [3:0]         kept_count_nxt;
  logic               header_match_r;
  logic               header_match_nxt;
  logic [7:0]         byte_a_r;
  logic [7:0]         byte_a_nxt;
  logic [7:0]         byte_b_r;
  logic [7:0]         byte_b_nxt;
  logic               digit_error_r;
  logic               digit_error_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [14:0] value_r;
  logic signed [14:0] value_nxt;
  logic [1:0]         status_r;
  logic [1:0]         status_nxt;
  logic               is_prompt;
  logic [3:0]         need;

  assign is_prompt = (item.cls == CLS_PROMPT);
  // A prompt waits while an undelivered result blocks the output register.
  assign pop       = item_valid && (!is_prompt || !out_valid_r || !out_stall);

  // Reply state update and result forming.
  always_comb begin
    kept_count_nxt   = kept_count_r;
    header_match_nxt = header_match_r;
    byte_a_nxt       = byte_a_r;
    byte_b_nxt       = byte_b_r;
    digit_error_nxt  = digit_error_r;
    value_nxt        = value_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r && out_stall;
    need             = (item.query_kind == QUERY_TEMP) ? NEED_TEMP : NEED_RPM;

    if (pop && is_prompt) begin
      out_valid_nxt = 1'b1;
      value_nxt     = '0;
      if (!header_match_r) begin
        status_nxt = STS_HEADER;
      end else if ((kept_count_r < need) || digit_error_r) begin
        status_nxt = STS_SHORT;
      end else begin
        status_nxt = STS_VALID;
        if (item.query_kind == QUERY_TEMP) begin
          value_nxt = {7'd0, byte_a_r} - TEMP_OFFSET;
        end else begin
          value_nxt = {1'b0, byte_a_r, byte_b_r[7:2]};
        end
      end
      kept_count_nxt   = '0;
      header_match_nxt = 1'b1;
      byte_a_nxt       = '0;
      byte_b_nxt       = '0;
      digit_error_nxt  = 1'b0;
    end else if (pop && (kept_count_r < KEPT_MAX)) begin
      kept_count_nxt = kept_count_r + 1'b1;
      if (kept_count_r < HEADER_LEN) begin
        if (!item.hdr_hit[kept_count_r[1:0]]) begin
          header_match_nxt = 1'b0;
        end
      end else if (kept_count_r < BYTE_B_POS) begin
        byte_a_nxt = {byte_a_r[3:0], item.nibble};
        if (!item.hex_ok) begin
          digit_error_nxt = 1'b1;
        end
      end else begin
        byte_b_nxt = {byte_b_r[3:0], item.nibble};
        if (!item.hex_ok && (item.query_kind == QUERY_RPM)) begin
          digit_error_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_count_r   <= '0;
      header_match_r <= 1'b1;
      byte_a_r       <= '0;
      byte_b_r       <= '0;
      digit_error_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      kept_count_r   <= kept_count_nxt;
      header_match_r <= header_match_nxt;
      byte_a_r       <= byte_a_nxt;
      byte_b_r       <= byte_b_nxt;
      digit_error_r  <= digit_error_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

>>> design/obd_pid_response_decoder.sv
// ----------------------------------------------------------------------------
// OBD-II PID reply decoder
// Decodes an adapter reply to an engine speed or coolant temperature query,
// one character per request, and gives one result per prompt character.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  in_rx_char[7:0]
//   out      output     out_valid/out_stall out_value[14:0] signed, out_status[1:0]
//   cfg      input      cfg_we             cfg_wdata (query kind)
//
// One character is accepted per cycle while the queue has room; the front end
// classifies it into the queue and the back end updates the reply state as it
// leaves the queue. A result appears in the output register the cycle after
// its prompt leaves the queue.
// Reset clears the query kind, the queue and the reply state.
// A stalled result holds the output register; characters drain until a prompt
// reaches the head, then wait behind it; in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module obd_pid_response_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_value,
  output logic [1:0]         out_status
);
  import obdprd_pkg::*;

  logic      push;
  chr_item_t push_item;
  logic      queue_full;
  logic      pop;
  logic      pop_valid;
  chr_item_t pop_item;

  // Front end: query kind register and character classification.
  obdprd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_char (in_rx_char),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Queue between front and back ends.
  obdprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // Back end: reply tracking and result register.
  obdprd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop_valid),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

>>> verif/tb_obd_pid_response_decoder.sv
// ----------------------------------------------------------------------------
// Testbench for the OBD-II PID reply decoder
// Sends adapter replies one character per request, both hand-picked and random,
// under both query kinds. Each character is run through a behavioural decoder
// kept inside the bench. Every reading that leaves the block is compared, field
// by field, with the oldest reading still expected. Both channels idle and
// stall at random, and the receiver holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_obd_pid_response_decoder;
  import obdprd_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 16;      // queue depth plus pipeline, with margin
  localparam int END_CYCLES    = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 300;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 115;
  localparam int NUM_CASES     = 19;

  // One decoded reading as it leaves the block.
  typedef struct packed {
    logic signed [14:0] value;
    logic [1:0]         status;
  } reading_t;

  // One hand-picked reply; flip_at is the character before which the query
  // kind is toggled, or -1 for none.
  typedef struct {
    string      text;
    logic       kind;
    int         flip_at;
    bit         typed;
    int         value;
    logic [1:0] status;
  } reply_case_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_char = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] out_value;
  logic [1:0]         out_status;

  // Bench copy of the query kind and of the reply being assembled.
  logic       cfg_kind = QUERY_RPM;
  logic [3:0] kept_n;
  logic       hdr_ok;
  logic [7:0] acc_a;
  logic [7:0] acc_b;
  logic       bad_digit;

  reading_t    pending_readings[$];
  logic [7:0]  reply_chars[$];
  reply_case_t reply_cases[NUM_CASES];

  int cycle_count = 0;
  int items_sent = 0;
  int readings_seen = 0;
  int mismatch_count = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;
  int status_seen[3] = '{0, 0, 0};
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold_req = 1'b0;

  obd_pid_response_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_char (in_rx_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hex value of a character; bit 4 set means it is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return 5'(c - CHAR_0);
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) return 5'(c - CHAR_UC_A + 8'd10);
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) return 5'(c - CHAR_LC_A + 8'd10);
    return 5'b10000;
  endfunction

  // Random hex digit, letters in either case.
  function automatic logic [7:0] rand_hex_char();
    logic [3:0] nib;
    nib = 4'($urandom_range(0, 15));
    if (nib < 4'd10) return CHAR_0 + 8'(nib);
    return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + 8'(nib - 4'd10);
  endfunction

  // Length of an idle or stall run: mostly short, now and then long.
  function automatic int pick_run();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic clear_reply_state();
    kept_n = '0;
    hdr_ok = 1'b1;
    acc_a = '0;
    acc_b = '0;
    bad_digit = 1'b0;
  endtask

  // Advances the bench decoder by one character; a prompt yields a reading.
  task automatic decode_reply_char(input logic [7:0] c, output bit got, output reading_t rd);
    logic [4:0] nib;
    logic [3:0] need;
    logic [7:0] want;
    got = 1'b0;
    rd = '0;
    if (c == CHAR_CR || c == CHAR_SPACE) return;
    if (c != CHAR_PROMPT) begin
      // Characters past the eighth kept one are dropped.
      if (kept_n < KEPT_MAX) begin
        case (kept_n)
          4'd0: if (c != CHAR_4) hdr_ok = 1'b0;
          4'd1: if (c != CHAR_1) hdr_ok = 1'b0;
          4'd2: if (c != CHAR_0) hdr_ok = 1'b0;
          4'd3: begin
            want = (cfg_kind == QUERY_TEMP) ? CHAR_5 : CHAR_UC_C;
            if (c != want) hdr_ok = 1'b0;
          end
          default: begin
            nib = hex_value(c);
            // A bad digit of byte B only matters for engine speed.
            if (nib[4]) begin
              nib = '0;
              if (kept_n < BYTE_B_POS || cfg_kind == QUERY_RPM) bad_digit = 1'b1;
            end
            if (kept_n < BYTE_B_POS) acc_a = {acc_a[3:0], nib[3:0]};
            else acc_b = {acc_b[3:0], nib[3:0]};
          end
        endcase
        kept_n = kept_n + 4'd1;
      end
      return;
    end
    // Prompt: the header check wins over length and digit checks.
    need = (cfg_kind == QUERY_TEMP) ? NEED_TEMP : NEED_RPM;
    got = 1'b1;
    if (!hdr_ok) begin
      rd.status = STS_HEADER;
    end else if (kept_n < need || bad_digit) begin
      rd.status = STS_SHORT;
    end else begin
      rd.status = STS_VALID;
      if (cfg_kind == QUERY_TEMP) rd.value = 15'({7'd0, acc_a}) - TEMP_OFFSET;
      else rd.value = 15'({acc_a, acc_b} >> 2);
    end
    clear_reply_state();
  endtask

  task automatic report_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offers one character, waits for it to be taken, then idles at random.
  task automatic send_char(input logic [7:0] c, input bit typed, input reading_t typed_r);
    bit       got;
    reading_t rd;
    int       gap;
    in_valid <= 1'b1;
    in_rx_char <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_reply_char(c, got, rd);
    if (got) pending_readings.push_back(typed ? typed_r : rd);
    items_sent++;
    if (!tx_steady && $urandom_range(0, 99) >= 55) begin
      gap = pick_run();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_query_kind(input logic kind);
    drain_block();
    cfg_we <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_kind = kind;
    cfg_writes++;
  endtask

  // Builds the kept characters of one random reply for the given query kind.
  task automatic build_reply(input logic kind);
    int pick;
    int keep;
    reply_chars.delete();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // Mostly a sound reply; wrong PID header for some.
      reply_chars.push_back(CHAR_4);
      reply_chars.push_back(CHAR_1);
      reply_chars.push_back(CHAR_0);
      if (pick >= 72) reply_chars.push_back((kind == QUERY_TEMP) ? CHAR_UC_C : CHAR_5);
      else reply_chars.push_back((kind == QUERY_TEMP) ? CHAR_5 : CHAR_UC_C);
      repeat ((kind == QUERY_RPM || $urandom_range(0, 2) == 0) ? 4 : 2)
        reply_chars.push_back(rand_hex_char());
      if (pick >= 60 && pick < 66) begin
        // One character replaced by any byte at all.
        reply_chars[$urandom_range(0, reply_chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick >= 66 && pick < 72) begin
        // Truncated reply.
        keep = $urandom_range(0, reply_chars.size() - 1);
        while (reply_chars.size() > keep) void'(reply_chars.pop_back());
      end else if (pick < 8) begin
        // Over-long reply.
        repeat ($urandom_range(1, 6)) reply_chars.push_back(rand_hex_char());
      end
    end else begin
      // Line noise.
      repeat ($urandom_range(0, 12)) reply_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Sends the built reply with scattered separators and a closing prompt.
  task automatic send_reply();
    reading_t none;
    none = '0;
    foreach (reply_chars[k]) begin
      if ($urandom_range(0, 9) == 0)
        send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_CR, 1'b0, none);
      send_char(reply_chars[k], 1'b0, none);
    end
    if ($urandom_range(0, 2) == 0) send_char(CHAR_CR, 1'b0, none);
    send_char(CHAR_PROMPT, 1'b0, none);
  endtask

  // Receiver: checks each reading taken and drives the stall at random.
  initial begin
    int       hold_left;
    int       run_left;
    reading_t got_r;
    reading_t exp_r;
    hold_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_stall) stall_cycles++;
      if (rst_n && out_valid && !out_stall) begin
        got_r = {out_value, out_status};
        readings_seen++;
        if (got_r.status < 2'd3) status_seen[got_r.status]++;
        if (pending_readings.size() == 0) begin
          report_fault($sformatf("Reading %0d arrived with none pending: value %0d status %0d",
                                 readings_seen, got_r.value, got_r.status));
        end else begin
          exp_r = pending_readings.pop_front();
          if (got_r.value !== exp_r.value)
            report_fault($sformatf("Reading %0d value: expected %0d, got %0d",
                                   readings_seen, exp_r.value, got_r.value));
          if (got_r.status !== exp_r.status)
            report_fault($sformatf("Reading %0d status: expected %0d, got %0d",
                                   readings_seen, exp_r.status, got_r.status));
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      // Stall drive: a long hold first, then random runs.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 99) >= 70) begin
        run_left = pick_run() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence: reset, hand-picked replies, then random phases.
  initial begin
    reading_t typed_r;
    int       target;
    clear_reply_state();
    reply_cases = '{
      '{"410C0000>",          QUERY_RPM,  -1, 1'b1, 0,     STS_VALID},
      '{"410CFFFF\015>",      QUERY_RPM,  -1, 1'b1, 16383, STS_VALID},
      '{"41 0C 1a f8\015>",   QUERY_RPM,  -1, 1'b0, 0,     STS_VALID},
      '{">",                  QUERY_RPM,  -1, 1'b1, 0,     STS_SHORT},
      '{"410c1234>",          QUERY_RPM,  -1, 1'b1, 0,     STS_HEADER},
      '{"410C12>",            QUERY_RPM,  -1, 1'b1, 0,     STS_SHORT},
      '{"410C12G4>",          QUERY_RPM,  -1, 1'b1, 0,     STS_SHORT},
      '{"41>",                QUERY_RPM,  -1, 1'b1, 0,     STS_SHORT},
      '{"5>",                 QUERY_RPM,  -1, 1'b1, 0,     STS_HEADER},
      '{"\377\200>",          QUERY_RPM,  -1, 1'b1, 0,     STS_HEADER},
      '{"410C12345678>",      QUERY_RPM,  -1, 1'b0, 0,     STS_VALID},
      '{"410500>",            QUERY_TEMP, -1, 1'b1, -40,   STS_VALID},
      '{"4105FF>",            QUERY_TEMP, -1, 1'b1, 215,   STS_VALID},
      '{"4105 7B zz>",        QUERY_TEMP, -1, 1'b0, 0,     STS_VALID},
      '{"410C7B>",            QUERY_TEMP, -1, 1'b1, 0,     STS_HEADER},
      '{"4105>",              QUERY_TEMP, -1, 1'b1, 0,     STS_SHORT},
      '{"4105X0>",            QUERY_TEMP, -1, 1'b1, 0,     STS_SHORT},
      '{"4105 7B>",           QUERY_RPM,   3, 1'b0, 0,     STS_VALID},
      '{"4105AAzz>",          QUERY_TEMP,  6, 1'b0, 0,     STS_VALID}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_query_kind(QUERY_RPM);

    // Hand-picked replies; a mid-reply toggle waits for the block to go idle.
    for (int i = 0; i < NUM_CASES; i++) begin
      if (reply_cases[i].kind != cfg_kind) write_query_kind(reply_cases[i].kind);
      typed_r.value = 15'(reply_cases[i].value);
      typed_r.status = reply_cases[i].status;
      for (int j = 0; j < reply_cases[i].text.len(); j++) begin
        if (j == reply_cases[i].flip_at) write_query_kind(!cfg_kind);
        send_char(reply_cases[i].text[j], reply_cases[i].typed, typed_r);
      end
    end

    // Random phases, each under its own query kind and idling pattern.
    target = items_sent;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_query_kind((phase < 2) ? phase[0] : logic'($urandom_range(0, 1)));
      tx_steady = (phase == 3 || phase == 5);
      rx_steady = (phase == 3);
      if (phase == 5) long_hold_req = 1'b1;
      target += PHASE_ITEMS;
      while (items_sent < target) begin
        build_reply(cfg_kind);
        send_reply();
      end
    end

    drain_block();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d characters under %0d query kind writes; %0d readings checked.",
             items_sent, cfg_writes, readings_seen);
    $display("Readings by status: %0d valid, %0d header, %0d short; input stalled %0d cycles.",
             status_seen[0], status_seen[1], status_seen[2], stall_cycles);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
